/* hdl/aia_pkg.sv */
// ----------------------------------------------------------------------------
// Accumulating integer ALU package
// Opcodes, error codes, field widths, sequencer states and the structs passed
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package aia_pkg;

	localparam int OP_W        = 32;
	localparam int KIND_W      = 5;
	localparam int ERR_W       = 2;
	localparam int IN_TUSER_W  = KIND_W + 1;
	localparam int OUT_TDATA_W = 40;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [ERR_W-1:0]  err_t;

	localparam kind_t K_ADD   = 5'd0;
	localparam kind_t K_SUB   = 5'd1;
	localparam kind_t K_MUL   = 5'd2;
	localparam kind_t K_DIV   = 5'd3;
	localparam kind_t K_REM   = 5'd4;
	localparam kind_t K_MIN   = 5'd5;
	localparam kind_t K_MAX   = 5'd6;
	localparam kind_t K_AND   = 5'd7;
	localparam kind_t K_OR    = 5'd8;
	localparam kind_t K_XOR   = 5'd9;
	localparam kind_t K_NOT   = 5'd10;
	localparam kind_t K_ABS   = 5'd11;
	localparam kind_t K_INC   = 5'd12;
	localparam kind_t K_DEC   = 5'd13;
	localparam kind_t K_NEGP  = 5'd14;
	localparam kind_t K_ZEROP = 5'd15;
	localparam kind_t K_POSP  = 5'd16;
	localparam kind_t K_EVENP = 5'd17;
	localparam kind_t K_ODDP  = 5'd18;
	localparam kind_t K_LT    = 5'd19;
	localparam kind_t K_LE    = 5'd20;
	localparam kind_t K_EQ    = 5'd21;
	localparam kind_t K_NE    = 5'd22;
	localparam kind_t K_GE    = 5'd23;
	localparam kind_t K_GT    = 5'd24;

	localparam err_t ERR_NONE  = 2'd0;
	localparam err_t ERR_DIV0  = 2'd1;
	localparam err_t ERR_COUNT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DNEG,
		ST_DIV,
		ST_DFIX,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic in_fire;
		logic start;
		logic is_mul;
		logic is_div;
		logic v_zero;
		logic itr_done;
		logic last;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic in_ready;
		logic emit;
	} seq_ctrl_t;

endpackage

/* hdl/aia_addsub.sv */
// ----------------------------------------------------------------------------
// Shared adder and subtractor
// One extra bit on top gives the exact signed compare or the unsigned borrow.
// ----------------------------------------------------------------------------
module aia_addsub #(
	parameter int W = 32
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         sub,
	input  logic         sgn,
	output logic [W:0]   sum
);

	logic [W:0] xe;
	logic [W:0] ye;

	assign xe  = {sgn & x[W-1], x};
	assign ye  = {sgn & y[W-1], y} ^ {(W+1){sub}};
	assign sum = xe + ye + {{W{1'b0}}, sub};

endmodule

/* hdl/aia_fsm.sv */
// ----------------------------------------------------------------------------
// Accumulating integer ALU sequencer
// Steps one request through execute, the multiply or divide loop and the
// result stage.
// ----------------------------------------------------------------------------
module aia_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  aia_pkg::seq_status_t status,
	output aia_pkg::state_t      state,
	output aia_pkg::seq_ctrl_t   ctrl
);

	aia_pkg::state_t state_q;
	aia_pkg::state_t state_d;
	aia_pkg::state_t after_op;

	assign after_op = status.last ? aia_pkg::ST_FINISH : aia_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aia_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aia_pkg::ST_IDLE: begin
				if (status.in_fire) state_d = aia_pkg::ST_EXEC;
			end
			aia_pkg::ST_EXEC: begin
				if (status.start) state_d = after_op;
				else if (status.is_mul) state_d = aia_pkg::ST_MUL;
				else if (status.is_div && !status.v_zero) state_d = aia_pkg::ST_DNEG;
				else state_d = after_op;
			end
			aia_pkg::ST_MUL: begin
				if (status.itr_done) state_d = after_op;
			end
			aia_pkg::ST_DNEG: begin
				state_d = aia_pkg::ST_DIV;
			end
			aia_pkg::ST_DIV: begin
				if (status.itr_done) state_d = aia_pkg::ST_DFIX;
			end
			aia_pkg::ST_DFIX: begin
				state_d = after_op;
			end
			aia_pkg::ST_FINISH: begin
				if (status.out_free) state_d = aia_pkg::ST_IDLE;
			end
			default: begin
				state_d = aia_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl.in_ready = (state_q == aia_pkg::ST_IDLE);
		ctrl.emit     = (state_q == aia_pkg::ST_FINISH) && status.out_free;
	end

	assign state = state_q;

endmodule

/* hdl/accumulating_integer_alu_top.sv */
// ----------------------------------------------------------------------------
// Accumulating integer ALU
// Folds a stream of signed operands into an accumulator and emits one result
// for each operand marked last.
// ----------------------------------------------------------------------------
// A request is accepted and then executed; multiply then runs its shift-and-add
// loop, and divide or remainder by a nonzero divisor takes the divisor magnitude,
// runs its loop at one quotient bit per cycle through the single shared adder
// and fixes the sign. An operand marked last then forms its result, and waits
// there while the previous result has not been taken. The input is ready only
// between requests.
module accumulating_integer_alu_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// operand
	input  logic [aia_pkg::OP_W-1:0]             s_axis_tdata,
	// kind, first_arg
	input  logic [aia_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// value, truth, error, zero fill
	output logic [aia_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int DW = DATA_WIDTH;
	localparam int IW = $clog2(DATA_WIDTH);

	aia_pkg::state_t      state;
	aia_pkg::seq_status_t status;
	aia_pkg::seq_ctrl_t   ctrl;

	logic [DW-1:0]   acc_q;
	logic [1:0]      cnt_q;
	aia_pkg::err_t   err_q;
	logic            out_valid_q;

	aia_pkg::kind_t  kind_q;
	logic [DW-1:0]   v_q;
	logic            first_q;
	logic            last_q;
	logic [DW-1:0]   p_q;
	logic [DW-1:0]   m_q;
	logic [DW-1:0]   q_q;
	logic [IW-1:0]   itr_q;
	logic            na_q;
	logic            nb_q;
	logic [aia_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [DW+aia_pkg::OP_W-1:0] op_ext;
	logic [DW-1:0]   x;
	logic [DW-1:0]   y;
	logic            sub;
	logic            sgn;
	logic [DW:0]     sum;
	logic            in_fire;
	logic            start;
	logic            out_free;
	logic [1:0]      cnt_inc;
	logic [DW-1:0]   r_sh;
	logic [DW-1:0]   div_res;
	logic            div_neg;

	logic [DW-1:0]   res_value;
	logic            res_truth;
	aia_pkg::err_t   res_err;
	logic [DW+aia_pkg::OP_W-1:0] res_ext;
	logic            eq_av;

	assign in_fire  = s_axis_tvalid && ctrl.in_ready;
	assign start    = first_q || (cnt_q == 2'd0);
	assign out_free = !out_valid_q || m_axis_tready;
	assign cnt_inc  = (cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1;
	assign op_ext   = {{DW{s_axis_tdata[aia_pkg::OP_W-1]}}, s_axis_tdata};
	assign r_sh     = {p_q[DW-2:0], q_q[DW-1]};
	assign div_res  = (kind_q == aia_pkg::K_REM) ? p_q : q_q;
	assign div_neg  = (kind_q == aia_pkg::K_REM) ? na_q : (na_q ^ nb_q);
	assign eq_av    = (acc_q == v_q);

	always_comb begin
		status.in_fire  = in_fire;
		status.start    = start;
		status.is_mul   = (kind_q == aia_pkg::K_MUL);
		status.is_div   = (kind_q == aia_pkg::K_DIV) || (kind_q == aia_pkg::K_REM);
		status.v_zero   = (v_q == '0);
		status.itr_done = (itr_q == '0);
		status.last     = last_q;
		status.out_free = out_free;
	end

	aia_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.state  (state),
		.ctrl   (ctrl)
	);

	aia_addsub #(.W(DW)) u_addsub (
		.x   (x),
		.y   (y),
		.sub (sub),
		.sgn (sgn),
		.sum (sum)
	);

	always_comb begin
		x   = acc_q;
		y   = v_q;
		sub = 1'b0;
		sgn = 1'b0;
		case (state)
			aia_pkg::ST_EXEC: begin
				case (kind_q)
					aia_pkg::K_SUB: begin
						sub = 1'b1;
					end
					aia_pkg::K_MIN: begin
						x   = v_q;
						y   = acc_q;
						sub = 1'b1;
						sgn = 1'b1;
					end
					aia_pkg::K_MAX: begin
						sub = 1'b1;
						sgn = 1'b1;
					end
					aia_pkg::K_DIV, aia_pkg::K_REM: begin
						x   = '0;
						y   = acc_q;
						sub = 1'b1;
					end
					default: begin
						sub = 1'b0;
					end
				endcase
			end
			aia_pkg::ST_MUL: begin
				x = p_q;
				y = m_q;
			end
			aia_pkg::ST_DNEG: begin
				x   = '0;
				y   = v_q;
				sub = 1'b1;
			end
			aia_pkg::ST_DIV: begin
				x   = r_sh;
				y   = m_q;
				sub = 1'b1;
			end
			aia_pkg::ST_DFIX: begin
				x   = '0;
				y   = div_res;
				sub = 1'b1;
			end
			aia_pkg::ST_FINISH: begin
				case (kind_q)
					aia_pkg::K_SUB, aia_pkg::K_ABS: begin
						x   = '0;
						y   = acc_q;
						sub = 1'b1;
					end
					aia_pkg::K_INC: begin
						y = DW'(1);
					end
					aia_pkg::K_DEC: begin
						y   = DW'(1);
						sub = 1'b1;
					end
					aia_pkg::K_LT, aia_pkg::K_LE, aia_pkg::K_EQ,
					aia_pkg::K_NE, aia_pkg::K_GE, aia_pkg::K_GT: begin
						sub = 1'b1;
						sgn = 1'b1;
					end
					default: begin
						sub = 1'b0;
					end
				endcase
			end
			default: begin
				sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_value = '0;
		res_truth = 1'b0;
		res_err   = err_q;
		case (kind_q)
			aia_pkg::K_NOT, aia_pkg::K_ABS, aia_pkg::K_INC, aia_pkg::K_DEC,
			aia_pkg::K_NEGP, aia_pkg::K_ZEROP, aia_pkg::K_POSP,
			aia_pkg::K_EVENP, aia_pkg::K_ODDP: begin
				if (cnt_q != 2'd1) begin
					res_err = aia_pkg::ERR_COUNT;
				end else begin
					case (kind_q)
						aia_pkg::K_NOT:   res_value = ~acc_q;
						aia_pkg::K_ABS:   res_value = acc_q[DW-1] ? sum[DW-1:0] : acc_q;
						aia_pkg::K_INC:   res_value = sum[DW-1:0];
						aia_pkg::K_DEC:   res_value = sum[DW-1:0];
						aia_pkg::K_NEGP:  res_truth = acc_q[DW-1];
						aia_pkg::K_ZEROP: res_truth = (acc_q == '0);
						aia_pkg::K_POSP:  res_truth = (acc_q != '0) && !acc_q[DW-1];
						aia_pkg::K_EVENP: res_truth = !acc_q[0];
						default:          res_truth = acc_q[0];
					endcase
				end
			end
			aia_pkg::K_LT, aia_pkg::K_LE, aia_pkg::K_EQ,
			aia_pkg::K_NE, aia_pkg::K_GE, aia_pkg::K_GT: begin
				if (cnt_q != 2'd2) begin
					res_err = aia_pkg::ERR_COUNT;
				end else begin
					case (kind_q)
						aia_pkg::K_LT: res_truth = sum[DW];
						aia_pkg::K_LE: res_truth = sum[DW] || eq_av;
						aia_pkg::K_EQ: res_truth = eq_av;
						aia_pkg::K_NE: res_truth = !eq_av;
						aia_pkg::K_GE: res_truth = !sum[DW];
						default:       res_truth = !sum[DW] && !eq_av;
					endcase
				end
			end
			default: begin
				if ((kind_q == aia_pkg::K_SUB) && (cnt_q == 2'd1)) begin
					res_value = sum[DW-1:0];
				end else begin
					res_value = acc_q;
				end
			end
		endcase
	end

	assign res_ext = {{aia_pkg::OP_W{res_value[DW-1]}}, res_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= 2'd0;
			err_q       <= aia_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state)
				aia_pkg::ST_EXEC: begin
					if (start) begin
						acc_q <= v_q;
						cnt_q <= 2'd1;
						err_q <= aia_pkg::ERR_NONE;
					end else begin
						cnt_q <= cnt_inc;
						case (kind_q)
							aia_pkg::K_ADD, aia_pkg::K_SUB: acc_q <= sum[DW-1:0];
							aia_pkg::K_MIN, aia_pkg::K_MAX: begin
								if (sum[DW]) acc_q <= v_q;
							end
							aia_pkg::K_DIV, aia_pkg::K_REM: begin
								if (v_q == '0) begin
									acc_q <= '0;
									err_q <= aia_pkg::ERR_DIV0;
								end
							end
							aia_pkg::K_AND: acc_q <= acc_q & v_q;
							aia_pkg::K_OR:  acc_q <= acc_q | v_q;
							aia_pkg::K_XOR: acc_q <= acc_q ^ v_q;
							default:        acc_q <= acc_q;
						endcase
					end
				end
				aia_pkg::ST_MUL: begin
					if (itr_q == '0) acc_q <= q_q[0] ? sum[DW-1:0] : p_q;
				end
				aia_pkg::ST_DFIX: begin
					acc_q <= div_neg ? sum[DW-1:0] : div_res;
				end
				aia_pkg::ST_FINISH: begin
					if (ctrl.emit) begin
						cnt_q <= 2'd0;
						err_q <= aia_pkg::ERR_NONE;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q  <= s_axis_tuser[aia_pkg::KIND_W-1:0];
			first_q <= s_axis_tuser[aia_pkg::KIND_W];
			last_q  <= s_axis_tlast;
			v_q     <= op_ext[DW-1:0];
		end
		case (state)
			aia_pkg::ST_EXEC: begin
				itr_q <= IW'(DW - 1);
				na_q  <= acc_q[DW-1];
				nb_q  <= v_q[DW-1];
				if (kind_q == aia_pkg::K_MUL) begin
					p_q <= '0;
					m_q <= acc_q;
					q_q <= v_q;
				end else begin
					p_q <= '0;
					q_q <= acc_q[DW-1] ? sum[DW-1:0] : acc_q;
				end
			end
			aia_pkg::ST_MUL: begin
				if (q_q[0]) p_q <= sum[DW-1:0];
				m_q   <= {m_q[DW-2:0], 1'b0};
				q_q   <= {1'b0, q_q[DW-1:1]};
				itr_q <= itr_q - IW'(1);
			end
			aia_pkg::ST_DNEG: begin
				m_q <= nb_q ? sum[DW-1:0] : v_q;
			end
			aia_pkg::ST_DIV: begin
				if (!sum[DW]) begin
					p_q <= sum[DW-1:0];
					q_q <= {q_q[DW-2:0], 1'b1};
				end else begin
					p_q <= r_sh;
					q_q <= {q_q[DW-2:0], 1'b0};
				end
				itr_q <= itr_q - IW'(1);
			end
			default: begin
				itr_q <= itr_q;
			end
		endcase
		if (ctrl.emit) begin
			out_data_q <= {{(aia_pkg::OUT_TDATA_W - aia_pkg::OP_W - aia_pkg::ERR_W - 1){1'b0}},
				res_err, res_truth, res_ext[aia_pkg::OP_W-1:0]};
		end
	end

	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	a_exec_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state == aia_pkg::ST_EXEC) |=> (cnt_q != 2'd0))
		else $error("operand count is zero after an executed request");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state == aia_pkg::ST_DIV) |-> (m_q != '0))
		else $error("divide loop running with a zero divisor");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> (cnt_q == 2'd0) && out_valid_q && (state == aia_pkg::ST_IDLE))
		else $error("result emitted without closing the operation");

	a_no_bad_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[aia_pkg::OP_W+aia_pkg::ERR_W:aia_pkg::OP_W+1] != 2'd3))
		else $error("undefined error code in result");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Accumulating integer ALU testbench
// Streams directed and random operand sequences into the ALU, computes the
// expected result of every request marked last with a behavioral model of the
// accumulator, and compares each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aia_pkg::*;

	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          PHASE_ITEMS  = 400;
	localparam int          DRAIN_CYCLES = 64;
	localparam kind_t       K_UNDEF      = 5'd31;
	localparam logic [31:0] OP_MIN       = 32'h8000_0000;
	localparam logic [31:0] OP_MAX       = 32'h7FFF_FFFF;
	localparam logic [31:0] OP_NEG1      = 32'hFFFF_FFFF;

	typedef struct {
		kind_t       kind;
		logic [31:0] operand;
		logic        first;
		logic        last;
	} alu_req_t;

	typedef struct {
		logic [31:0] value;
		logic        truth;
		err_t        error;
	} alu_res_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OP_W-1:0]        s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                   s_axis_tlast  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	alu_req_t    request_queue[$];
	alu_res_t    awaited_results[$];
	int          send_idle_pct = 32;
	int          recv_idle_pct = 75;
	int          failures      = 0;
	int          cycle_count   = 0;

	logic [31:0] fold_acc   = '0;
	logic [1:0]  fold_count = '0;
	err_t        fold_err   = ERR_NONE;

	accumulating_integer_alu_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] trunc_divide(logic [31:0] a, logic [31:0] b,
			bit want_rem);
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] quot;
		logic [31:0] remd;
		mag_a = a[31] ? 32'd0 - a : a;
		mag_b = b[31] ? 32'd0 - b : b;
		quot  = mag_a / mag_b;
		remd  = mag_a % mag_b;
		if (want_rem)
			return a[31] ? 32'd0 - remd : remd;
		return (a[31] ^ b[31]) ? 32'd0 - quot : quot;
	endfunction

	// Updates the accumulator state and returns 1 when the request emits a result.
	function automatic bit compute_alu_result(input alu_req_t r, output alu_res_t res);
		logic [31:0] a;
		logic        lt;
		logic        eq;
		res.value = '0;
		res.truth = 1'b0;
		res.error = ERR_NONE;
		if (r.first || fold_count == 2'd0) begin
			fold_acc   = r.operand;
			fold_count = 2'd1;
			fold_err   = ERR_NONE;
		end else begin
			case (r.kind)
				K_ADD: fold_acc = fold_acc + r.operand;
				K_SUB: fold_acc = fold_acc - r.operand;
				K_MUL: fold_acc = fold_acc * r.operand;
				K_DIV, K_REM: begin
					if (r.operand == '0) begin
						fold_acc = '0;
						fold_err = ERR_DIV0;
					end else begin
						fold_acc = trunc_divide(fold_acc, r.operand, r.kind == K_REM);
					end
				end
				K_MIN: if ($signed(r.operand) < $signed(fold_acc)) fold_acc = r.operand;
				K_MAX: if ($signed(fold_acc) < $signed(r.operand)) fold_acc = r.operand;
				K_AND: fold_acc = fold_acc & r.operand;
				K_OR:  fold_acc = fold_acc | r.operand;
				K_XOR: fold_acc = fold_acc ^ r.operand;
				default: ;
			endcase
			if (fold_count != 2'd3)
				fold_count = fold_count + 2'd1;
		end
		if (!r.last)
			return 1'b0;

		a         = fold_acc;
		res.error = fold_err;
		if (r.kind <= K_XOR || r.kind > K_GT) begin
			res.value = (r.kind == K_SUB && fold_count == 2'd1) ? 32'd0 - a : a;
		end else if (r.kind <= K_ODDP) begin
			if (fold_count != 2'd1) begin
				res.error = ERR_COUNT;
			end else begin
				case (r.kind)
					K_NOT:   res.value = ~a;
					K_ABS:   res.value = a[31] ? 32'd0 - a : a;
					K_INC:   res.value = a + 32'd1;
					K_DEC:   res.value = a - 32'd1;
					K_NEGP:  res.truth = a[31];
					K_ZEROP: res.truth = (a == '0);
					K_POSP:  res.truth = (a != '0) && !a[31];
					K_EVENP: res.truth = !a[0];
					default: res.truth = a[0];
				endcase
			end
		end else begin
			if (fold_count != 2'd2) begin
				res.error = ERR_COUNT;
			end else begin
				lt = $signed(a) < $signed(r.operand);
				eq = (a == r.operand);
				case (r.kind)
					K_LT:    res.truth = lt;
					K_LE:    res.truth = lt || eq;
					K_EQ:    res.truth = eq;
					K_NE:    res.truth = !eq;
					K_GE:    res.truth = !lt;
					default: res.truth = !lt && !eq;
				endcase
			end
		end
		fold_count = 2'd0;
		fold_err   = ERR_NONE;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_req_t taken;
		alu_req_t next_req;
		alu_res_t res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken.kind    = s_axis_tuser[KIND_W-1:0];
				taken.first   = s_axis_tuser[KIND_W];
				taken.operand = s_axis_tdata;
				taken.last    = s_axis_tlast;
				if (compute_alu_result(taken, res))
					awaited_results.push_back(res);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = request_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_req.operand;
					s_axis_tuser  <= {next_req.first, next_req.kind};
					s_axis_tlast  <= next_req.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		alu_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: tdata %h", m_axis_tdata);
					failures++;
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tdata[31:0] !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
						failures++;
					end
					if (m_axis_tdata[32] !== want.truth) begin
						$error("truth: expected %b, got %b", want.truth, m_axis_tdata[32]);
						failures++;
					end
					if (m_axis_tdata[34:33] !== want.error) begin
						$error("error: expected %0d, got %0d", want.error, m_axis_tdata[34:33]);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_request(kind_t kind, logic [31:0] operand, logic first, logic last);
		alu_req_t r;
		r.kind    = kind;
		r.operand = operand;
		r.first   = first;
		r.last    = last;
		request_queue.push_back(r);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 32'd1;
			2:       return OP_NEG1;
			3:       return OP_MIN;
			4:       return OP_MAX;
			5, 6:    return 32'($urandom_range(20)) - 32'd10;
			default: return $urandom();
		endcase
	endfunction

	// One operation, mostly well formed, occasionally a stray request.
	task automatic push_operation(inout int count);
		int    pick;
		int    len;
		kind_t kind;
		kind_t step_kind;
		pick = $urandom_range(99);
		if (pick < 8) begin
			push_request(kind_t'($urandom_range(31)), random_operand(),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			count++;
			return;
		end
		if (pick < 50) begin
			kind = kind_t'($urandom_range(K_XOR));
			len  = $urandom_range(1, 4);
		end else if (pick < 80) begin
			kind = kind_t'($urandom_range(K_NOT, K_ODDP));
			len  = ($urandom_range(99) < 85) ? 1 : $urandom_range(2, 3);
		end else if (pick < 96) begin
			kind = kind_t'($urandom_range(K_LT, K_GT));
			len  = ($urandom_range(99) < 85) ? 2 : (($urandom_range(1) != 0) ? 1 : 3);
		end else begin
			kind = kind_t'($urandom_range(K_GT + 1, K_UNDEF));
			len  = $urandom_range(1, 3);
		end
		for (int i = 0; i < len; i++) begin
			step_kind = kind;
			if (i > 0 && i < len - 1 && $urandom_range(9) == 0)
				step_kind = kind_t'($urandom_range(31));
			push_request(step_kind, random_operand(),
				(i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
				i == len - 1);
			count++;
		end
	endtask

	task automatic run_phase(int send_pct, int recv_pct);
		int count;
		count         = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (count < PHASE_ITEMS)
			push_operation(count);
		while (request_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	initial begin
		push_request(K_ADD,   OP_MAX,  1'b1, 1'b0);
		push_request(K_ADD,   32'd1,   1'b0, 1'b0);
		push_request(K_ADD,   OP_MIN,  1'b0, 1'b1);
		push_request(K_SUB,   OP_MIN,  1'b1, 1'b1);
		push_request(K_DIV,   OP_MIN,  1'b1, 1'b0);
		push_request(K_DIV,   OP_NEG1, 1'b0, 1'b1);
		push_request(K_REM,   OP_MIN,  1'b1, 1'b0);
		push_request(K_REM,   OP_NEG1, 1'b0, 1'b1);
		push_request(K_DIV,   32'd7,   1'b1, 1'b0);
		push_request(K_DIV,   32'd0,   1'b0, 1'b0);
		push_request(K_MUL,   -32'd3,  1'b0, 1'b1);
		push_request(K_MIN,   32'd3,   1'b1, 1'b0);
		push_request(K_MAX,   -32'd4,  1'b0, 1'b0);
		push_request(K_AND,   32'd7,   1'b0, 1'b0);
		push_request(K_OR,    32'd8,   1'b0, 1'b0);
		push_request(K_XOR,   OP_NEG1, 1'b0, 1'b1);
		push_request(K_ABS,   OP_MIN,  1'b1, 1'b1);
		push_request(K_NOT,   32'd0,   1'b0, 1'b1);
		push_request(K_INC,   OP_MAX,  1'b1, 1'b1);
		push_request(K_DEC,   OP_MIN,  1'b1, 1'b1);
		push_request(K_EQ,    32'd5,   1'b1, 1'b0);
		push_request(K_LT,    OP_MAX,  1'b0, 1'b1);
		push_request(K_NEGP,  32'd3,   1'b1, 1'b0);
		push_request(K_ZEROP, 32'd0,   1'b1, 1'b0);
		push_request(K_ZEROP, 32'd0,   1'b0, 1'b1);
		push_request(K_UNDEF, 32'd9,   1'b1, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		run_phase(32, 75);
		run_phase(75, 32);
		run_phase(0, 0);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
